// File: rtl/psr_pkg.sv
// shared types, constants and control/status bundles for parent selection
// no dependencies; every rtl file but psr_ram refers to this package by scoped names
package psr_pkg;

   // population size and derived index widths
   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // field and arithmetic widths
   localparam int ENERGY_W  = 32;
   localparam int WEIGHT_W  = 41;
   localparam int TOTAL_W   = 47;
   localparam int FRAC_W    = 24;
   localparam int PARENT_W  = 6;
   localparam int PROD_W    = 2 * FRAC_W;
   localparam int DIV_STEPS = WEIGHT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [ENERGY_W-1:0]  energy_type;
   typedef logic [WEIGHT_W-1:0]  weight_type;
   typedef logic [TOTAL_W-1:0]   total_type;
   typedef logic [FRAC_W-1:0]    frac_type;
   typedef logic [PARENT_W-1:0]  parent_type;
   typedef logic [PROD_W-1:0]    prod_type;
   typedef logic [DIV_CNT_W-1:0] div_cnt_type;

   // operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   // selection modes
   localparam logic MODE_ROULETTE = 1'b0;
   localparam logic MODE_BEST     = 1'b1;

   // request and response payloads
   typedef struct packed {
      logic       operation;
      energy_type energy;
      logic       last_entry;
      frac_type   random_fraction;
   } req_type;

   typedef struct packed {
      parent_type parent_index;
      logic       none_left;
   } rsp_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOAD_WR,
      ST_LOAD_END,
      ST_MUL,
      ST_SUM,
      ST_WALK,
      ST_BEST_RD,
      ST_BEST_TAKE,
      ST_RESULT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic start;
      logic div_step;
      logic load_write;
      logic load_end;
      logic mul;
      logic sum;
      logic walk;
      logic best_read;
      logic best_take;
      logic result_load;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic load_full;
      logic div_last;
      logic roulette;
      logic total_zero;
      logic walk_hit;
      logic walk_end;
      logic found;
      logic out_free;
   } status_type;

endpackage

// File: rtl/psr_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module psr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/psr_ctrl.sv
// sequencing state machine for loads and draws
// depends on psr_pkg for state, command and status types
module psr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_stall,
   input  psr_pkg::status_type  status,
   output psr_pkg::cmd_type     cmd
);

   psr_pkg::state_type state_ff;
   psr_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psr_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == psr_pkg::OP_DRAW) begin
                  state_in = status.roulette ? psr_pkg::ST_MUL : psr_pkg::ST_WALK;
               end else begin
                  state_in = status.load_full ? psr_pkg::ST_LOAD_END : psr_pkg::ST_DIV;
               end
            end
         end
         psr_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = psr_pkg::ST_LOAD_WR;
            end
         end
         psr_pkg::ST_LOAD_WR: begin
            state_in = psr_pkg::ST_LOAD_END;
         end
         psr_pkg::ST_LOAD_END: begin
            state_in = psr_pkg::ST_IDLE;
         end
         psr_pkg::ST_MUL: begin
            state_in = psr_pkg::ST_SUM;
         end
         psr_pkg::ST_SUM: begin
            state_in = status.total_zero ? psr_pkg::ST_RESULT : psr_pkg::ST_WALK;
         end
         psr_pkg::ST_WALK: begin
            if (status.walk_hit) begin
               state_in = psr_pkg::ST_RESULT;
            end else if (status.walk_end) begin
               if (!status.roulette && status.found) begin
                  state_in = psr_pkg::ST_BEST_RD;
               end else begin
                  state_in = psr_pkg::ST_RESULT;
               end
            end
         end
         psr_pkg::ST_BEST_RD: begin
            state_in = psr_pkg::ST_BEST_TAKE;
         end
         psr_pkg::ST_BEST_TAKE: begin
            state_in = psr_pkg::ST_RESULT;
         end
         psr_pkg::ST_RESULT: begin
            if (status.out_free) begin
               state_in = psr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psr_pkg::ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         psr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         psr_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         psr_pkg::ST_LOAD_WR: begin
            cmd.load_write = 1'b1;
         end
         psr_pkg::ST_LOAD_END: begin
            cmd.load_end = 1'b1;
         end
         psr_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         psr_pkg::ST_SUM: begin
            cmd.sum = 1'b1;
         end
         psr_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
         end
         psr_pkg::ST_BEST_RD: begin
            cmd.best_read = 1'b1;
         end
         psr_pkg::ST_BEST_TAKE: begin
            cmd.best_take = 1'b1;
         end
         psr_pkg::ST_RESULT: begin
            cmd.result_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: rtl/psr_dpath.sv
// datapath: serial divider, weight and energy stores, entry walk, result register
// depends on psr_pkg and psr_ram
module psr_dpath (
   input  logic                clock,
   input  logic                reset,
   input  psr_pkg::req_type    req_data,
   output psr_pkg::rsp_type    rsp_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   input  psr_pkg::cmd_type    cmd,
   output psr_pkg::status_type status
);

   // control registers
   logic                       mode_ff, mode_in;
   psr_pkg::total_type         total_ff, total_in;
   psr_pkg::cnt_type           load_ptr_ff, load_ptr_in;
   psr_pkg::cnt_type           count_ff, count_in;
   logic [psr_pkg::MAX_ENTRIES-1:0] marks_ff, marks_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload registers
   psr_pkg::energy_type        energy_ff, energy_in;
   logic                       last_ff, last_in;
   psr_pkg::frac_type          frac_ff, frac_in;
   psr_pkg::energy_type        rem_ff, rem_in;
   psr_pkg::weight_type        quo_ff, quo_in;
   psr_pkg::div_cnt_type       div_cnt_ff, div_cnt_in;
   psr_pkg::total_type         prod_hi_ff, prod_hi_in;
   psr_pkg::prod_type          prod_lo_ff, prod_lo_in;
   psr_pkg::total_type         test_ff, test_in;
   psr_pkg::cnt_type           issue_ff, issue_in;
   psr_pkg::idx_type           pend_idx_ff, pend_idx_in;
   logic                       found_ff, found_in;
   psr_pkg::idx_type           best_idx_ff, best_idx_in;
   psr_pkg::energy_type        best_e_ff, best_e_in;
   psr_pkg::idx_type           pick_ff, pick_in;
   psr_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   // memory ports
   logic                       w_wr_en;
   psr_pkg::idx_type           w_wr_addr;
   psr_pkg::weight_type        w_wr_data;
   psr_pkg::weight_type        w_rd_data;
   psr_pkg::energy_type        e_rd_data;
   psr_pkg::idx_type           rd_addr;

   // combinational helpers
   logic [psr_pkg::ENERGY_W:0] div_shift;
   logic [psr_pkg::ENERGY_W:0] div_diff;
   logic                       div_ge;
   logic                       roulette;
   logic                       test_less;
   logic                       hit;
   logic                       take_en;
   psr_pkg::idx_type           take_idx;

   assign roulette  = (mode_ff == psr_pkg::MODE_ROULETTE);
   assign test_less = (test_ff < psr_pkg::total_type'(w_rd_data));
   assign hit       = rd_pend_ff && roulette && test_less;
   assign take_en   = (cmd.walk && hit) || cmd.best_take;
   assign take_idx  = cmd.best_take ? best_idx_ff : pend_idx_ff;

   // one quotient bit per step; the dividend is a single one at the top bit
   assign div_shift = {rem_ff, (div_cnt_ff == '0)};
   assign div_diff  = div_shift - {1'b0, energy_ff};
   assign div_ge    = (div_shift >= {1'b0, energy_ff});

   // shared read address for both stores
   assign rd_addr = cmd.best_read ? best_idx_ff : issue_ff[psr_pkg::IDX_W-1:0];

   // weight store write: new weight on load, zero on take
   always_comb begin
      w_wr_en   = cmd.load_write || take_en;
      w_wr_addr = cmd.load_write ? load_ptr_ff[psr_pkg::IDX_W-1:0] : take_idx;
      w_wr_data = cmd.load_write ? quo_ff : '0;
   end

   psr_ram #(
      .WIDTH (psr_pkg::WEIGHT_W),
      .DEPTH (psr_pkg::MAX_ENTRIES)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (w_wr_data),
      .rd_addr (rd_addr),
      .rd_data (w_rd_data)
   );

   psr_ram #(
      .WIDTH (psr_pkg::ENERGY_W),
      .DEPTH (psr_pkg::MAX_ENTRIES)
   ) u_energy_ram (
      .clock   (clock),
      .wr_en   (cmd.load_write),
      .wr_addr (load_ptr_ff[psr_pkg::IDX_W-1:0]),
      .wr_data (energy_ff),
      .rd_addr (rd_addr),
      .rd_data (e_rd_data)
   );

   // next-value logic
   always_comb begin
      mode_in      = mode_ff;
      total_in     = total_ff;
      load_ptr_in  = load_ptr_ff;
      count_in     = count_ff;
      marks_in     = marks_ff;
      rd_pend_in   = rd_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      energy_in    = energy_ff;
      last_in      = last_ff;
      frac_in      = frac_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      prod_hi_in   = prod_hi_ff;
      prod_lo_in   = prod_lo_ff;
      test_in      = test_ff;
      issue_in     = issue_ff;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_e_in    = best_e_ff;
      pick_in      = pick_ff;
      rsp_data_in  = rsp_data_ff;

      // mode register
      if (csr_write_enable) begin
         mode_in = csr_write_data;
      end

      // capture transaction and reset per-item state
      if (cmd.start) begin
         energy_in  = (req_data.energy == '0) ? psr_pkg::energy_type'(1) : req_data.energy;
         last_in    = req_data.last_entry;
         frac_in    = req_data.random_fraction;
         rem_in     = '0;
         div_cnt_in = '0;
         issue_in   = '0;
         rd_pend_in = 1'b0;
         found_in   = 1'b0;
         if (req_data.operation == psr_pkg::OP_LOAD && load_ptr_ff == '0) begin
            total_in = '0;
         end
      end

      // serial reciprocal
      if (cmd.div_step) begin
         rem_in     = div_ge ? div_diff[psr_pkg::ENERGY_W-1:0]
                             : div_shift[psr_pkg::ENERGY_W-1:0];
         quo_in     = {quo_ff[psr_pkg::WEIGHT_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff + psr_pkg::div_cnt_type'(1);
      end

      // store the new entry
      if (cmd.load_write) begin
         total_in    = total_ff + psr_pkg::total_type'(quo_ff);
         load_ptr_in = load_ptr_ff + psr_pkg::cnt_type'(1);
      end

      // close the set
      if (cmd.load_end && last_ff) begin
         count_in    = load_ptr_ff;
         load_ptr_in = '0;
         marks_in    = '0;
      end

      // roulette scaling, split into high and low partial products
      if (cmd.mul) begin
         prod_hi_in = psr_pkg::total_type'(frac_ff)
                    * psr_pkg::total_type'(total_ff[psr_pkg::TOTAL_W-1:psr_pkg::FRAC_W]);
         prod_lo_in = psr_pkg::prod_type'(frac_ff)
                    * psr_pkg::prod_type'(total_ff[psr_pkg::FRAC_W-1:0]);
      end
      if (cmd.sum) begin
         test_in = prod_hi_ff
                 + psr_pkg::total_type'(prod_lo_ff[psr_pkg::PROD_W-1:psr_pkg::FRAC_W]);
      end

      // entry walk: issue one read a cycle, evaluate the entry read last cycle
      if (cmd.walk) begin
         if (issue_ff < count_ff) begin
            issue_in    = issue_ff + psr_pkg::cnt_type'(1);
            rd_pend_in  = 1'b1;
            pend_idx_in = issue_ff[psr_pkg::IDX_W-1:0];
         end else begin
            rd_pend_in = 1'b0;
         end
         if (rd_pend_ff) begin
            if (roulette) begin
               if (test_less) begin
                  found_in = 1'b1;
                  pick_in  = pend_idx_ff;
               end else begin
                  test_in = test_ff - psr_pkg::total_type'(w_rd_data);
               end
            end else if (!marks_ff[pend_idx_ff] && (!found_ff || e_rd_data < best_e_ff)) begin
               found_in    = 1'b1;
               best_idx_in = pend_idx_ff;
               best_e_in   = e_rd_data;
            end
         end
      end

      // lowest-energy pick
      if (cmd.best_take) begin
         pick_in = best_idx_ff;
      end

      // remove the chosen entry from the wheel
      if (take_en) begin
         total_in           = total_in - psr_pkg::total_type'(w_rd_data);
         marks_in[take_idx] = 1'b1;
      end

      // result register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.result_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.parent_index = found_ff ? psr_pkg::parent_type'(pick_ff) : '0;
         rsp_data_in.none_left    = !found_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= psr_pkg::MODE_ROULETTE;
         total_ff     <= '0;
         load_ptr_ff  <= '0;
         count_ff     <= '0;
         marks_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         total_ff     <= total_in;
         load_ptr_ff  <= load_ptr_in;
         count_ff     <= count_in;
         marks_ff     <= marks_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      energy_ff   <= energy_in;
      last_ff     <= last_in;
      frac_ff     <= frac_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      prod_hi_ff  <= prod_hi_in;
      prod_lo_ff  <= prod_lo_in;
      test_ff     <= test_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      found_ff    <= found_in;
      best_idx_ff <= best_idx_in;
      best_e_ff   <= best_e_in;
      pick_ff     <= pick_in;
      rsp_data_ff <= rsp_data_in;
   end

   // status to controller
   always_comb begin
      status.load_full  = (load_ptr_ff >= psr_pkg::cnt_type'(psr_pkg::MAX_ENTRIES));
      status.div_last   = (div_cnt_ff == psr_pkg::div_cnt_type'(psr_pkg::DIV_STEPS - 1));
      status.roulette   = roulette;
      status.total_zero = (total_ff == '0);
      status.walk_hit   = hit;
      status.walk_end   = !rd_pend_ff && (issue_ff >= count_ff);
      status.found      = found_ff;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/parent_selection_roulette_core.sv
// Parent selection by inverse-energy roulette without replacement, or lowest energy
// first, over up to psr_pkg::MAX_ENTRIES entries. One transaction is handled at a
// time. A load runs the serial divider that forms floor(2^40/energy) one quotient
// bit per cycle (41 steps), then writes the entry; a load into a full store skips
// the divider and writes nothing. A roulette draw scales the total by the random
// fraction, then walks the entries until one is hit or the set ends; a roulette
// draw on an empty total skips the walk. A lowest-energy draw walks every entry,
// then reads back and takes the best one if any is left. The entry walk reads one
// store entry per cycle through the single read port of each store. A
// finished result sits in an output register, so the next request is accepted
// while it still waits on rsp_stall. The user must see that select_mode is written
// through csr_ only while the block is idle; the block itself does not enforce this.
// depends on psr_pkg, psr_ctrl, psr_dpath
module parent_selection_roulette_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  psr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output psr_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);

   psr_pkg::cmd_type    cmd;
   psr_pkg::status_type status;

   // sequencing
   psr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // storage and arithmetic
   psr_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// File: rtl/psr_checker.sv
// port-level checks for the parent selection core, attached by bind
// depends on psr_pkg and parent_selection_roulette_core
module psr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input psr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input psr_pkg::rsp_type rsp_data
);

   // a stalled result transaction stays valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result transaction keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // an empty draw reports index zero
   a_none_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.none_left |-> rsp_data.parent_index == '0)
      else $error("none_left with nonzero index");

   // a load never produces a result
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.operation == psr_pkg::OP_LOAD) && !rsp_valid
      |=> !rsp_valid)
      else $error("result appeared after a load");

   // one transaction at a time: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted on back-to-back cycles");

endmodule

bind parent_selection_roulette_core psr_checker u_psr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
